/* hw/rtl/nplc_pkg.sv */
// ----------------------------------------------------------------------------
// nplc_pkg: shared types and helpers for the nibble pair link codec
// Result kinds, decoder phases, the job that travels from the front end to
// the back end, and the 4b/8b symbol map in both directions.
// ----------------------------------------------------------------------------
package nplc_pkg;

    // Depth of the job queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Most results one item can cause, and the index width to walk them
    localparam int MAX_RES = 4;
    localparam int RIW     = $clog2(MAX_RES);

    typedef enum logic [1:0] {
        KIND_SYMBOL  = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_HDR_OK  = 2'd2,
        KIND_HDR_BAD = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } t_dec_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        frame_end;
    } t_res;

    // One accepted item worth of results, emitted res[0] up to res[last_idx]
    typedef struct packed {
        logic [RIW-1:0]         last_idx;
        t_res [MAX_RES-1:0]     res;
    } t_job;

    // Double every nibble bit: 1 -> 10, 0 -> 01
    function automatic logic [7:0] sym_of(input logic [3:0] nib);
        logic [7:0] s;
        for (int i = 0; i < 4; i++) begin
            s[2*i+1] = nib[i];
            s[2*i]   = ~nib[i];
        end
        return s;
    endfunction

    // Map a received symbol back to a nibble; header forms (low pair 00)
    // give the even nibble, anything unknown gives 0
    function automatic logic [3:0] nib_of(input logic [7:0] s);
        logic [3:0] n;
        logic       ok_hi;
        ok_hi = 1'b1;
        for (int i = 1; i < 4; i++) begin
            n[i]  = s[2*i+1];
            ok_hi = ok_hi & (s[2*i+1] ^ s[2*i]);
        end
        n[0] = s[1];
        if (!ok_hi) begin
            return 4'd0;
        end else if (s[1:0] == 2'b00) begin
            return {n[3:1], 1'b0};
        end else if (s[1] ^ s[0]) begin
            return n;
        end else begin
            return 4'd0;
        end
    endfunction

    function automatic t_res mk_res(input t_kind kind, input logic [7:0] data,
                                    input logic frame_end);
        t_res r;
        r.kind      = kind;
        r.data      = data;
        r.frame_end = frame_end;
        return r;
    endfunction

endpackage

/* hw/rtl/nplc_front.sv */
// ----------------------------------------------------------------------------
// nplc_front: item intake and classification
// Accepts items, keeps the encoder and decoder frame state, and turns each
// item that causes results into a job listing them.
// ----------------------------------------------------------------------------
module nplc_front
    import nplc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_action,
    input  logic [7:0] i_value,
    input  logic [2:0] i_command,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_wr,
    output t_job       o_job
);

    logic       r_in_frame, n_in_frame;
    t_dec_phase r_phase,    n_phase;
    logic [3:0] r_held,     n_held;

    logic       accept;
    logic [7:0] sym_lo, sym_hi, sym_hdr;
    logic [3:0] nib;

    assign o_full = i_q_full;
    assign accept = i_push & ~i_q_full;

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_phase    <= PH_HDR;
            r_held     <= 4'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_phase    <= n_phase;
            r_held     <= n_held;
        end
    end

    assign sym_lo  = sym_of(i_value[3:0]);
    assign sym_hi  = sym_of(i_value[7:4]);
    assign sym_hdr = sym_of({i_command, 1'b0}) & 8'hfc;
    assign nib     = nib_of(i_value);

    // Classify the item, build its job and advance frame state
    always_comb begin
        n_in_frame = r_in_frame;
        n_phase    = r_phase;
        n_held     = r_held;
        o_job      = '0;
        o_wr       = 1'b0;
        if (accept) begin
            if (!i_action) begin
                o_wr = 1'b1;
                if (!r_in_frame) begin
                    o_job.res[0]   = mk_res(KIND_SYMBOL, sym_hdr, 1'b0);
                    o_job.res[1]   = mk_res(KIND_SYMBOL, sym_lo, 1'b0);
                    o_job.res[2]   = mk_res(KIND_SYMBOL, sym_hi, 1'b0);
                    o_job.res[3]   = mk_res(KIND_SYMBOL, 8'h00, 1'b1);
                    o_job.last_idx = i_last ? RIW'(3) : RIW'(2);
                end else begin
                    o_job.res[0]   = mk_res(KIND_SYMBOL, sym_lo, 1'b0);
                    o_job.res[1]   = mk_res(KIND_SYMBOL, sym_hi, 1'b0);
                    o_job.res[2]   = mk_res(KIND_SYMBOL, 8'h00, 1'b1);
                    o_job.last_idx = i_last ? RIW'(2) : RIW'(1);
                end
                n_in_frame = ~i_last;
            end else begin
                case (r_phase)
                    PH_LOW: begin
                        if (i_last) begin
                            o_wr         = 1'b1;
                            o_job.res[0] = mk_res(KIND_BYTE, {4'd0, nib}, 1'b1);
                            n_phase      = PH_HDR;
                            n_held       = 4'd0;
                        end else begin
                            n_held  = nib;
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        o_wr         = 1'b1;
                        o_job.res[0] = mk_res(KIND_BYTE, {nib, r_held}, i_last);
                        n_phase      = i_last ? PH_HDR : PH_LOW;
                        n_held       = 4'd0;
                    end
                    default: begin
                        // Header check: only nibble 14 or 15 opens a frame
                        o_wr = 1'b1;
                        if (nib[3:1] == 3'b111) begin
                            o_job.res[0] = mk_res(KIND_HDR_OK, 8'h00, 1'b0);
                            n_phase      = i_last ? PH_HDR : PH_LOW;
                        end else begin
                            o_job.res[0] = mk_res(KIND_HDR_BAD, 8'h00, 1'b0);
                            n_phase      = PH_HDR;
                        end
                        n_held = 4'd0;
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/nplc_queue.sv */
// ----------------------------------------------------------------------------
// nplc_queue: job queue between front and back end
// Small register queue; write and read may happen in the same cycle.
// ----------------------------------------------------------------------------
module nplc_queue
    import nplc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("job written into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("job read from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a write");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd && !i_wr) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count lost a read");

endmodule

/* hw/rtl/nplc_back.sv */
// ----------------------------------------------------------------------------
// nplc_back: result emitter
// Walks the results of the head job, one per cycle while the output register is free or being popped, into it.
// ----------------------------------------------------------------------------
module nplc_back
    import nplc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_job i_job,
    output logic o_q_rd,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    logic           r_out_valid;
    t_res           r_out;
    logic [RIW-1:0] r_idx;
    logic           load;

    assign load    = i_q_valid & (~r_out_valid | i_pop);
    assign o_q_rd  = load & (r_idx == i_job.last_idx);
    assign o_empty = ~r_out_valid;
    assign o_res   = r_out;

    // Advance through the job and drop it after its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= o_q_rd ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_job.res[r_idx];
        end
    end

endmodule

/* hw/rtl/nibble_pair_link_codec.sv */
// ----------------------------------------------------------------------------
// nibble_pair_link_codec: 4b/8b framing codec, encode and decode
// Input side is a queue write port: present an item with i_push while o_full
// is low. i_action 0 encodes a payload byte, 1 decodes one line symbol.
// Result side is a queue read port: while o_empty is low the oldest result
// sits on o_kind / o_data_out / o_frame_end; i_pop takes it.
// An encoded byte gives two symbols, plus a header at frame start and a
// terminator on the last byte (2 to 4 results). A decoded symbol gives zero
// or one result.
// With the job queue and output register free, an accepted item's job is
// written into the queue, then its first result is loaded into the output register.
// The back end emits one result per cycle while the receiver keeps popping; the
// front end takes an item every cycle until the four-entry job queue fills.
// Reset (synchronous, active low) empties the queue and output register and
// returns both encoder and decoder to "waiting for frame start".
// A stalled receiver only fills the queue; o_full then holds off the sender.
// No result is ever dropped.
// ----------------------------------------------------------------------------
module nibble_pair_link_codec
    import nplc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_action,
    input  logic [7:0] i_value,
    input  logic [2:0] i_command,
    input  logic       i_last,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_out,
    output logic       o_frame_end
);

    logic q_full, q_wr, q_rd, q_valid;
    t_job wr_job, rd_job;
    t_res res;

    nplc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_action  (i_action),
        .i_value   (i_value),
        .i_command (i_command),
        .i_last    (i_last),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_wr      (q_wr),
        .o_job     (wr_job)
    );

    nplc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (wr_job),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (rd_job)
    );

    nplc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (rd_job),
        .o_q_rd    (q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (res)
    );

    assign o_kind      = res.kind;
    assign o_data_out  = res.data;
    assign o_frame_end = res.frame_end;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the nibble pair link codec
// A short table of directed items, then random encode and decode frames,
// goes in through the push/full port. Every popped result is compared with
// the oldest one forecast by a local 4b/8b codec model. Both sides idle in
// random bursts, and the result side holds off once to back the block up.
// ----------------------------------------------------------------------------
module tb;
    import nplc_pkg::*;

    localparam int   CLK_PERIOD  = 10;
    localparam logic ACT_ENCODE  = 1'b0;
    localparam logic ACT_DECODE  = 1'b1;
    localparam int   N_DIR       = 24;
    localparam int   N_ITEMS     = 430;
    localparam int   TAIL_ITEMS  = 60;
    localparam int   HOLD_AT     = 150;
    localparam int   HOLD_CYCLES = 120;
    localparam int   MAX_SHOWN   = 10;
    localparam t_res NO_RES      = '0;

    // One stimulus item; known results are used in place of the model when set
    typedef struct packed {
        logic       action;
        logic [7:0] value;
        logic [2:0] command;
        logic       last;
        logic [2:0] n_known;
        t_res [3:0] known;
    } t_stim;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_push      = 1'b0;
    logic       i_action    = 1'b0;
    logic [7:0] i_value     = 8'h00;
    logic [2:0] i_command   = 3'd0;
    logic       i_last      = 1'b0;
    logic       i_pop       = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [1:0] o_kind;
    logic [7:0] o_data_out;
    logic       o_frame_end;

    t_res       pending_out_q [$];
    int         mismatches   = 0;
    int         accepted_cnt = 0;
    logic       quiet_tail   = 1'b0;

    // Codec model state
    logic       enc_open;
    t_dec_phase dec_phase;
    logic [3:0] dec_low_nib;

    nibble_pair_link_codec u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_command   (i_command),
        .i_last      (i_last),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_kind      (o_kind),
        .o_data_out  (o_data_out),
        .o_frame_end (o_frame_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Spread each nibble bit, msb first, into 10 for a one and 01 for a zero
    function automatic logic [7:0] line_sym(input logic [3:0] nib);
        logic [7:0] s;
        s = 8'h00;
        for (int i = 3; i >= 0; i--) begin
            s = {s[5:0], nib[i] ? 2'b10 : 2'b01};
        end
        return s;
    endfunction

    // Recover a nibble; header forms give the even nibble, junk gives zero
    function automatic logic [3:0] sym_nib(input logic [7:0] s);
        logic [3:0] nb;
        for (int n = 0; n < 16; n++) begin
            nb = n[3:0];
            if (line_sym(nb) == s) return nb;
            if ((line_sym(nb) & 8'hfc) == s) return nb & 4'he;
        end
        return 4'h0;
    endfunction

    function automatic t_res rslt(input t_kind kind, input logic [7:0] data,
                                  input logic fe);
        t_res r;
        r.kind      = kind;
        r.data      = data;
        r.frame_end = fe;
        return r;
    endfunction

    function automatic t_stim row_calc(input logic act, input logic [7:0] val,
                                       input logic [2:0] cmd, input logic lst);
        t_stim r;
        r         = '0;
        r.action  = act;
        r.value   = val;
        r.command = cmd;
        r.last    = lst;
        return r;
    endfunction

    function automatic t_stim row_known(input logic act, input logic [7:0] val,
                                        input logic [2:0] cmd, input logic lst,
                                        input logic [2:0] n, input t_res r0,
                                        input t_res r1, input t_res r2,
                                        input t_res r3);
        t_stim r;
        r          = row_calc(act, val, cmd, lst);
        r.n_known  = n;
        r.known[0] = r0;
        r.known[1] = r1;
        r.known[2] = r2;
        r.known[3] = r3;
        return r;
    endfunction

    // Forecast the results of one accepted item and advance the model state
    task automatic compute_codec_out(input t_stim it);
        logic [3:0] nib;
        logic       hdr_ok;
        if (it.action == ACT_ENCODE) begin
            if (!enc_open) begin
                pending_out_q.push_back(rslt(KIND_SYMBOL,
                    line_sym({it.command, 1'b0}) & 8'hfc, 1'b0));
                enc_open = 1'b1;
            end
            pending_out_q.push_back(rslt(KIND_SYMBOL, line_sym(it.value[3:0]), 1'b0));
            pending_out_q.push_back(rslt(KIND_SYMBOL, line_sym(it.value[7:4]), 1'b0));
            if (it.last) begin
                pending_out_q.push_back(rslt(KIND_SYMBOL, 8'h00, 1'b1));
                enc_open = 1'b0;
            end
        end else begin
            nib = sym_nib(it.value);
            case (dec_phase)
                PH_LOW: begin
                    // a lone final symbol stands in for a byte with high nibble zero
                    if (it.last) begin
                        pending_out_q.push_back(rslt(KIND_BYTE, {4'h0, nib}, 1'b1));
                        dec_phase   = PH_HDR;
                        dec_low_nib = 4'h0;
                    end else begin
                        dec_low_nib = nib;
                        dec_phase   = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    pending_out_q.push_back(rslt(KIND_BYTE, {nib, dec_low_nib}, it.last));
                    dec_phase   = it.last ? PH_HDR : PH_LOW;
                    dec_low_nib = 4'h0;
                end
                default: begin
                    // header: only nibbles 14 and 15 open a frame
                    hdr_ok = (nib[3:1] == 3'b111);
                    pending_out_q.push_back(rslt(hdr_ok ? KIND_HDR_OK : KIND_HDR_BAD,
                                                 8'h00, 1'b0));
                    dec_phase   = (hdr_ok && !it.last) ? PH_LOW : PH_HDR;
                    dec_low_nib = 4'h0;
                end
            endcase
        end
    endtask

    task automatic note_mismatch(input string why, input t_res want);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t: %s: expected kind %0d data %02h end %0b, got kind %0d data %02h end %0b",
                     $time, why, want.kind, want.data, want.frame_end,
                     o_kind, o_data_out, o_frame_end);
        end
    endtask

    // Compare each popped result with the oldest forecast
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_out_q.size() == 0) begin
                note_mismatch("result with none pending", NO_RES);
            end else begin
                want = pending_out_q.pop_front();
                if (o_kind !== want.kind || o_data_out !== want.data ||
                    o_frame_end !== want.frame_end) begin
                    note_mismatch("wrong result", want);
                end
            end
        end
    end

    // Send side: build the item list, reset, then offer items in order
    initial begin : sender
        t_stim      dir_tab [N_DIR];
        t_stim      stim_q [$];
        t_stim      it;
        int         n0;
        int         nbyte;
        int         nsym;
        logic [7:0] hdr;
        logic [7:0] sym;

        dir_tab = '{
            row_known(ACT_ENCODE, 8'h00, 3'd7, 1'b0, 3'd3,
                      rslt(KIND_SYMBOL, 8'ha8, 1'b0), rslt(KIND_SYMBOL, 8'h55, 1'b0),
                      rslt(KIND_SYMBOL, 8'h55, 1'b0), NO_RES),
            row_known(ACT_ENCODE, 8'hff, 3'd0, 1'b1, 3'd3,
                      rslt(KIND_SYMBOL, 8'haa, 1'b0), rslt(KIND_SYMBOL, 8'haa, 1'b0),
                      rslt(KIND_SYMBOL, 8'h00, 1'b1), NO_RES),
            row_known(ACT_ENCODE, 8'ha5, 3'd3, 1'b1, 3'd4,
                      rslt(KIND_SYMBOL, 8'h68, 1'b0), rslt(KIND_SYMBOL, 8'h66, 1'b0),
                      rslt(KIND_SYMBOL, 8'h99, 1'b0), rslt(KIND_SYMBOL, 8'h00, 1'b1)),
            row_calc(ACT_ENCODE, 8'h3c, 3'd0, 1'b0),
            row_calc(ACT_ENCODE, 8'h5a, 3'd5, 1'b0),
            row_calc(ACT_ENCODE, 8'h81, 3'd2, 1'b1),
            row_known(ACT_DECODE, 8'ha8, 3'd0, 1'b0, 3'd1,
                      rslt(KIND_HDR_OK, 8'h00, 1'b0), NO_RES, NO_RES, NO_RES),
            row_calc(ACT_DECODE, 8'h66, 3'd0, 1'b0),
            row_known(ACT_DECODE, 8'h99, 3'd0, 1'b0, 3'd1,
                      rslt(KIND_BYTE, 8'ha5, 1'b0), NO_RES, NO_RES, NO_RES),
            row_calc(ACT_DECODE, 8'h55, 3'd0, 1'b0),
            row_known(ACT_DECODE, 8'haa, 3'd0, 1'b1, 3'd1,
                      rslt(KIND_BYTE, 8'hf0, 1'b1), NO_RES, NO_RES, NO_RES),
            row_known(ACT_DECODE, 8'haa, 3'd0, 1'b0, 3'd1,
                      rslt(KIND_HDR_OK, 8'h00, 1'b0), NO_RES, NO_RES, NO_RES),
            row_known(ACT_DECODE, 8'h5a, 3'd0, 1'b1, 3'd1,
                      rslt(KIND_BYTE, 8'h03, 1'b1), NO_RES, NO_RES, NO_RES),
            row_known(ACT_DECODE, 8'h00, 3'd7, 1'b0, 3'd1,
                      rslt(KIND_HDR_BAD, 8'h00, 1'b0), NO_RES, NO_RES, NO_RES),
            row_known(ACT_DECODE, 8'hff, 3'd7, 1'b1, 3'd1,
                      rslt(KIND_HDR_BAD, 8'h00, 1'b0), NO_RES, NO_RES, NO_RES),
            row_calc(ACT_DECODE, 8'ha9, 3'd0, 1'b1),
            row_calc(ACT_DECODE, 8'h54, 3'd0, 1'b0),
            row_calc(ACT_DECODE, 8'hab, 3'd0, 1'b0),
            row_known(ACT_DECODE, 8'ha8, 3'd0, 1'b0, 3'd1,
                      rslt(KIND_HDR_OK, 8'h00, 1'b0), NO_RES, NO_RES, NO_RES),
            row_calc(ACT_DECODE, 8'h03, 3'd0, 1'b0),
            row_calc(ACT_DECODE, 8'hff, 3'd0, 1'b0),
            row_calc(ACT_DECODE, 8'h64, 3'd0, 1'b0),
            row_calc(ACT_DECODE, 8'h96, 3'd0, 1'b1),
            row_calc(ACT_ENCODE, 8'h00, 3'd7, 1'b1)
        };
        for (int r = 0; r < N_DIR; r++) begin
            stim_q.push_back(dir_tab[r]);
        end

        // Random frames: mostly well formed, with junk symbols and lost ends mixed in
        while (stim_q.size() < N_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                nbyte = $urandom_range(1, 5);
                for (int b = 0; b < nbyte; b++) begin
                    stim_q.push_back(row_calc(ACT_ENCODE, 8'($urandom), 3'($urandom),
                                              b == nbyte - 1));
                end
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    hdr = 8'($urandom);
                end else begin
                    hdr = line_sym({3'b111, 1'($urandom)});
                    if ($urandom_range(0, 1) == 0) hdr = hdr & 8'hfc;
                end
                stim_q.push_back(row_calc(ACT_DECODE, hdr, 3'($urandom),
                                          $urandom_range(0, 19) == 0));
                nsym = $urandom_range(1, 7);
                for (int s = 0; s < nsym; s++) begin
                    case ($urandom_range(0, 19))
                        0:       sym = 8'($urandom);
                        1:       sym = line_sym(4'($urandom)) & 8'hfc;
                        default: sym = line_sym(4'($urandom));
                    endcase
                    stim_q.push_back(row_calc(ACT_DECODE, sym, 3'($urandom),
                                              s == nsym - 1 && $urandom_range(0, 9) != 0));
                end
            end
        end

        // Hold reset, then release it on a falling edge
        enc_open    = 1'b0;
        dec_phase   = PH_HDR;
        dec_low_nib = 4'h0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < stim_q.size(); idx++) begin
            it = stim_q[idx];
            if (stim_q.size() - idx <= TAIL_ITEMS) quiet_tail = 1'b1;
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_push    <= 1'b1;
            i_action  <= it.action;
            i_value   <= it.value;
            i_command <= it.command;
            i_last    <= it.last;
            do @(posedge i_clk); while (o_full);
            n0 = pending_out_q.size();
            compute_codec_out(it);
            if (it.n_known != 0) begin
                while (pending_out_q.size() > n0) void'(pending_out_q.pop_back());
                for (int k = 0; k < it.n_known; k++) pending_out_q.push_back(it.known[k]);
            end
            accepted_cnt++;
            @(negedge i_clk);
        end
        i_push <= 1'b0;

        // Drain, then give any stray result time to show up
        while (pending_out_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("nibble_pair_link_codec test passed");
        end else begin
            $display("nibble_pair_link_codec test failed");
        end
        $finish;
    end

    // Receive side: random pop bursts, one long hold-off to fill the block
    initial begin : receiver
        int   idle_left;
        int   hold_left;
        logic held;
        idle_left = 0;
        hold_left = 0;
        held      = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && accepted_cnt >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (quiet_tail) begin
                i_pop <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                i_pop <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(1, 12) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #2_000_000;
        $display("nibble_pair_link_codec test failed");
        $finish;
    end

endmodule

/* nibble_pair_link_codec.f */
hw/rtl/nplc_pkg.sv
hw/rtl/nplc_front.sv
hw/rtl/nplc_queue.sv
hw/rtl/nplc_back.sv
hw/rtl/nibble_pair_link_codec.sv
bench/tb.sv
